/* sv/addressable_led_bit_encoder_macros.svh */
// assertion macros of the encoder rtl
// no dependencies; included by the files that carry assertions
`ifndef ADDRESSABLE_LED_BIT_ENCODER_MACROS_SVH
`define ADDRESSABLE_LED_BIT_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define ALED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ALED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ALED_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ALED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/aled_pkg.sv */
// types and constants of the addressable led bit encoder
// no dependencies; imported by all encoder modules, used by name in the interfaces
package aled_pkg;

	localparam int COLOR_W         = 8;
	localparam int TIME_W          = 10;
	localparam int LATCH_W         = 16;
	localparam int BITS_PER_PIXEL  = 3 * COLOR_W;
	localparam int IDX_W           = $clog2(BITS_PER_PIXEL + 1);
	localparam int PADDR_W         = 5;
	localparam int PDATA_W         = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [TIME_W-1:0]  ZERO_HIGH_RST = TIME_W'(30);
	localparam logic [TIME_W-1:0]  ZERO_LOW_RST  = TIME_W'(68);
	localparam logic [TIME_W-1:0]  ONE_HIGH_RST  = TIME_W'(68);
	localparam logic [TIME_W-1:0]  ONE_LOW_RST   = TIME_W'(30);
	localparam logic [LATCH_W-1:0] LATCH_RST     = LATCH_W'(5000);

	typedef enum logic [2:0] {
		REG_ZERO_HIGH = 3'd0,
		REG_ZERO_LOW  = 3'd1,
		REG_ONE_HIGH  = 3'd2,
		REG_ONE_LOW   = 3'd3,
		REG_LATCH     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0]  zero_high;
		logic [TIME_W-1:0]  zero_low;
		logic [TIME_W-1:0]  one_high;
		logic [TIME_W-1:0]  one_low;
		logic [LATCH_W-1:0] latch;
	} cfg_t;

	typedef struct packed {
		logic [BITS_PER_PIXEL-1:0] word;
		logic                      frame_end;
	} pix_entry_t;

	typedef struct packed {
		logic       valid;
		pix_entry_t entry;
	} q_slot_t;

endpackage

/* sv/aled_if.sv */
// channel interfaces: pixel requests in, pulse requests out
// depends on aled_pkg
interface aled_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [aled_pkg::COLOR_W-1:0] green;
	logic [aled_pkg::COLOR_W-1:0] red;
	logic [aled_pkg::COLOR_W-1:0] blue;
	logic                         frame_end;

	modport source(output valid, green, red, blue, frame_end, input ready);
	modport sink(input valid, green, red, blue, frame_end, output ready);
endinterface

interface aled_pulse_if;
	logic                         valid;
	logic                         ready;
	logic [aled_pkg::TIME_W-1:0]  high_time;
	logic [aled_pkg::LATCH_W-1:0] low_time;
	logic                         data_bit;
	logic                         is_latch;
	logic                         run_last;

	modport source(output valid, high_time, low_time, data_bit, is_latch, run_last,
		input ready);
	modport sink(input valid, high_time, low_time, data_bit, is_latch, run_last,
		output ready);
endinterface

/* sv/aled_cfg.sv */
// apb register file holding the pulse timing
// depends on aled_pkg
module aled_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [aled_pkg::PADDR_W-1:0] paddr,
	input  logic [aled_pkg::PDATA_W-1:0] pwdata,
	output logic [aled_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output aled_pkg::cfg_t               cfg
);
	import aled_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= ZERO_HIGH_RST;
			cfg_q.zero_low  <= ZERO_LOW_RST;
			cfg_q.one_high  <= ONE_HIGH_RST;
			cfg_q.one_low   <= ONE_LOW_RST;
			cfg_q.latch     <= LATCH_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ZERO_HIGH: cfg_q.zero_high <= pwdata[TIME_W-1:0];
				REG_ZERO_LOW:  cfg_q.zero_low  <= pwdata[TIME_W-1:0];
				REG_ONE_HIGH:  cfg_q.one_high  <= pwdata[TIME_W-1:0];
				REG_ONE_LOW:   cfg_q.one_low   <= pwdata[TIME_W-1:0];
				REG_LATCH:     cfg_q.latch     <= pwdata[LATCH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ZERO_HIGH: prdata = PDATA_W'(cfg_q.zero_high);
			REG_ZERO_LOW:  prdata = PDATA_W'(cfg_q.zero_low);
			REG_ONE_HIGH:  prdata = PDATA_W'(cfg_q.one_high);
			REG_ONE_LOW:   prdata = PDATA_W'(cfg_q.one_low);
			REG_LATCH:     prdata = PDATA_W'(cfg_q.latch);
			default:       prdata = '0;
		endcase
	end

endmodule

/* sv/aled_front.sv */
// front stage: takes pixel requests and packs them into queue entries
// depends on aled_pkg and aled_pixel_if
module aled_front (
	input  logic              clk,
	input  logic              arst_n,
	aled_pixel_if.sink        pixel,
	output aled_pkg::q_slot_t push,
	input  logic              push_ready
);
	import aled_pkg::*;

	logic       v_s1;
	pix_entry_t entry_s1;
	logic       take;

	assign pixel.ready = !v_s1 || push_ready;
	assign take        = pixel.valid && pixel.ready;
	assign push.valid  = v_s1;
	assign push.entry  = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// green goes out first, so it sits in the top byte
	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.word      <= {pixel.green, pixel.red, pixel.blue};
			entry_s1.frame_end <= pixel.frame_end;
		end
	end

endmodule

/* sv/aled_fifo.sv */
// short queue of packed pixels between front and back
// depends on aled_pkg
module aled_fifo #(
	parameter int DEPTH = aled_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  aled_pkg::q_slot_t push,
	output logic              push_ready,
	output aled_pkg::q_slot_t head,
	input  logic              pop
);
	import aled_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pix_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = cnt_q != '0;
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

endmodule

/* sv/aled_back.sv */
// back stage: serializes a pixel into 24 bit pulses plus an optional latch gap
// depends on aled_pkg, aled_pulse_if and the assertion macros
`include "addressable_led_bit_encoder_macros.svh"
module aled_back (
	input  logic              clk,
	input  logic              arst_n,
	input  aled_pkg::cfg_t    cfg,
	input  aled_pkg::q_slot_t head,
	output logic              pop,
	aled_pulse_if.source      pulse
);
	import aled_pkg::*;

	logic                      busy_q;
	logic [BITS_PER_PIXEL-1:0] word_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      fe_q;

	logic                 ov_q;
	logic [TIME_W-1:0]    high_q;
	logic [LATCH_W-1:0]   low_q;
	logic                 bit_q;
	logic                 latch_q;
	logic                 last_q;

	logic                      advance;
	logic                      go;
	logic [BITS_PER_PIXEL-1:0] cur_word;
	logic [IDX_W-1:0]          cur_idx;
	logic                      cur_fe;
	logic                      r_latch;
	logic                      r_bit;
	logic                      r_last;

	assign advance  = !ov_q || pulse.ready;
	assign go       = busy_q || head.valid;
	assign pop      = advance && !busy_q && head.valid;
	assign cur_word = busy_q ? word_q : head.entry.word;
	assign cur_idx  = busy_q ? idx_q : '0;
	assign cur_fe   = busy_q ? fe_q : head.entry.frame_end;

	// after the last data bit only a frame end pixel is still busy
	assign r_latch = cur_idx == IDX_W'(BITS_PER_PIXEL);
	assign r_bit   = !r_latch && cur_word[BITS_PER_PIXEL-1];
	assign r_last  = r_latch || (!cur_fe && cur_idx == IDX_W'(BITS_PER_PIXEL - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			idx_q  <= '0;
		end else if (advance) begin
			ov_q <= go;
			if (go) begin
				busy_q <= !r_last;
				idx_q  <= cur_idx + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && go) begin
			word_q  <= {cur_word[BITS_PER_PIXEL-2:0], 1'b0};
			fe_q    <= cur_fe;
			bit_q   <= r_bit;
			latch_q <= r_latch;
			last_q  <= r_last;
			if (r_latch) begin
				high_q <= '0;
				low_q  <= cfg.latch;
			end else if (r_bit) begin
				high_q <= cfg.one_high;
				low_q  <= LATCH_W'(cfg.one_low);
			end else begin
				high_q <= cfg.zero_high;
				low_q  <= LATCH_W'(cfg.zero_low);
			end
		end
	end

	assign pulse.valid     = ov_q;
	assign pulse.high_time = high_q;
	assign pulse.low_time  = low_q;
	assign pulse.data_bit  = bit_q;
	assign pulse.is_latch  = latch_q;
	assign pulse.run_last  = last_q;

	`ALED_ASSERT_IMPL(a_idx_range, clk, arst_n, busy_q, idx_q <= IDX_W'(BITS_PER_PIXEL))
	`ALED_ASSERT_IMPL(a_latch_needs_fe, clk, arst_n, busy_q && !fe_q,
		idx_q != IDX_W'(BITS_PER_PIXEL))
	`ALED_ASSERT_NEXT(a_pop_starts_bit, clk, arst_n, pop,
		ov_q && !latch_q && !last_q && busy_q)

endmodule

/* sv/addressable_led_bit_encoder.sv */
// a pixel passes the front register, the pixel queue and the pulse register
// throughput: one pulse per cycle while pulses are taken; 24 pulses per
// pixel, 25 with frame end, set by the back stage serializer; the pixel queue
// lets the front keep taking pixels while a pulse waits to be taken
// reset: timing registers load their defaults, queue and pipeline empty at once
module addressable_led_bit_encoder #(
	parameter int QUEUE_DEPTH = aled_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	aled_pixel_if.sink                   pixel,
	aled_pulse_if.source                 pulse,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [aled_pkg::PADDR_W-1:0] paddr,
	input  logic [aled_pkg::PDATA_W-1:0] pwdata,
	output logic [aled_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import aled_pkg::*;

	cfg_t    cfg;
	q_slot_t push;
	q_slot_t head;
	logic    push_ready;
	logic    pop;

	aled_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	aled_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.push       (push),
		.push_ready (push_ready)
	);

	aled_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	aled_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.pop    (pop),
		.pulse  (pulse)
	);

endmodule

/* verif/addressable_led_bit_encoder_test.sv */
// self-checking testbench of the addressable led bit encoder: pixels in, pulse requests out
// holds a pulse predictor with its own copy of the timing registers, written over apb
// depends on aled_pkg, aled_if and the encoder rtl
module addressable_led_bit_encoder_test;
	import aled_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_PIXELS  = 88;
	localparam int MAX_REPORTS   = 10;
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef enum int {RX_STEADY, RX_RANDOM, RX_SLOW, RX_CHOPPY} rx_mode_t;

	typedef struct packed {
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] blue;
		logic               frame_end;
	} pixel_t;

	typedef struct packed {
		logic [TIME_W-1:0]  high_time;
		logic [LATCH_W-1:0] low_time;
		logic               data_bit;
		logic               is_latch;
		logic               run_last;
	} pulse_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	aled_pixel_if pixel_ch();
	aled_pulse_if pulse_ch();

	addressable_led_bit_encoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel_ch),
		.pulse   (pulse_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cfg_t        timing_regs;
	pixel_t      pixel_q[$];
	pulse_t      expected_pulses[$];
	pixel_t      pix_on_bus;
	int unsigned pixels_queued;
	int unsigned pixels_taken;
	int unsigned frames_taken;
	int unsigned pulses_checked;
	int unsigned fail_count;
	int unsigned reg_writes;
	int unsigned timing_sets;
	int unsigned long_stalls_req;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pulses still awaited",
				cycle_count, expected_pulses.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// pulses a pixel must produce under the current timing registers
	function automatic void expand_pixel(pixel_t px);
		logic [BITS_PER_PIXEL-1:0] word;
		pulse_t                    p;
		word = {px.green, px.red, px.blue};
		for (int i = BITS_PER_PIXEL - 1; i >= 0; i--) begin
			p.data_bit  = word[i];
			p.high_time = word[i] ? timing_regs.one_high : timing_regs.zero_high;
			p.low_time  = word[i] ? LATCH_W'(timing_regs.one_low) : LATCH_W'(timing_regs.zero_low);
			p.is_latch  = 1'b0;
			p.run_last  = !px.frame_end && (i == 0);
			expected_pulses.push_back(p);
		end
		if (px.frame_end) begin
			p.data_bit  = 1'b0;
			p.high_time = '0;
			p.low_time  = timing_regs.latch;
			p.is_latch  = 1'b1;
			p.run_last  = 1'b1;
			expected_pulses.push_back(p);
		end
	endfunction

	// pixel driver: bursts of requests with random gaps between them
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk) begin
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				expand_pixel(pix_on_bus);
				pixels_taken++;
				if (pix_on_bus.frame_end)
					frames_taken++;
			end
			if (!pixel_ch.valid || pixel_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					pixel_ch.valid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					pix_on_bus = pixel_q.pop_front();
					pixel_ch.valid     <= 1'b1;
					pixel_ch.green     <= pix_on_bus.green;
					pixel_ch.red       <= pix_on_bus.red;
					pixel_ch.blue      <= pix_on_bus.blue;
					pixel_ch.frame_end <= pix_on_bus.frame_end;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end else begin
						burst_left--;
					end
				end else begin
					pixel_ch.valid <= 1'b0;
				end
			end
		end
	end

	// pulse receiver: picks a new stall pattern at random, with long hold-offs on request
	rx_mode_t    rx_mode;
	int unsigned rx_mode_left;
	int unsigned rx_tick;
	int unsigned hold_left;
	int unsigned stalls_served;

	always @(posedge clk) begin
		if (!arst_n) begin
			pulse_ch.ready <= 1'b0;
			rx_mode       = RX_STEADY;
			rx_mode_left  = 0;
			rx_tick       = 0;
			hold_left     = 0;
			stalls_served = 0;
		end else begin
			if (stalls_served != long_stalls_req) begin
				stalls_served = long_stalls_req;
				hold_left     = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				pulse_ch.ready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode      = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(20, 200);
				end
				rx_mode_left--;
				rx_tick++;
				case (rx_mode)
					RX_STEADY: pulse_ch.ready <= 1'b1;
					RX_RANDOM: pulse_ch.ready <= ($urandom_range(0, 9) < 6);
					RX_SLOW:   pulse_ch.ready <= (rx_tick % 3 == 0);
					default:   pulse_ch.ready <= (rx_tick[3:2] != 2'b11);
				endcase
			end
		end
	end

	// pulse monitor: each taken pulse against the oldest expectation
	always @(posedge clk) begin
		pulse_t got;
		pulse_t want;
		if (arst_n && pulse_ch.valid && pulse_ch.ready) begin
			got.high_time = pulse_ch.high_time;
			got.low_time  = pulse_ch.low_time;
			got.data_bit  = pulse_ch.data_bit;
			got.is_latch  = pulse_ch.is_latch;
			got.run_last  = pulse_ch.run_last;
			if (expected_pulses.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("unexpected pulse: high %0d low %0d bit %0d latch %0d last %0d",
						got.high_time, got.low_time, got.data_bit, got.is_latch, got.run_last);
				fail_count++;
			end else begin
				want = expected_pulses.pop_front();
				pulses_checked++;
				if (got.high_time !== want.high_time || got.low_time !== want.low_time ||
						got.data_bit !== want.data_bit || got.is_latch !== want.is_latch ||
						got.run_last !== want.run_last) begin
					if (fail_count < MAX_REPORTS) begin
						$display("pulse %0d mismatch: expected high %0d low %0d bit %0d latch %0d last %0d",
							pulses_checked, want.high_time, want.low_time, want.data_bit,
							want.is_latch, want.run_last);
						$display("  actual high %0d low %0d bit %0d latch %0d last %0d",
							got.high_time, got.low_time, got.data_bit, got.is_latch, got.run_last);
					end
					fail_count++;
				end
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ZERO_HIGH: timing_regs.zero_high = value[TIME_W-1:0];
			REG_ZERO_LOW:  timing_regs.zero_low  = value[TIME_W-1:0];
			REG_ONE_HIGH:  timing_regs.one_high  = value[TIME_W-1:0];
			REG_ONE_LOW:   timing_regs.one_low   = value[TIME_W-1:0];
			REG_LATCH:     timing_regs.latch     = value[LATCH_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_timing(logic [PDATA_W-1:0] zh, logic [PDATA_W-1:0] zl,
			logic [PDATA_W-1:0] oh, logic [PDATA_W-1:0] ol, logic [PDATA_W-1:0] lt);
		cfg_write(REG_ZERO_HIGH, zh);
		cfg_write(REG_ZERO_LOW, zl);
		cfg_write(REG_ONE_HIGH, oh);
		cfg_write(REG_ONE_LOW, ol);
		cfg_write(REG_LATCH, lt);
		timing_sets++;
	endtask

	task automatic queue_pixel(logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] b, logic fe);
		pixel_t px;
		px.green     = g;
		px.red       = r;
		px.blue      = b;
		px.frame_end = fe;
		pixel_q.push_back(px);
		pixels_queued++;
	endtask

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 8'h80;
			3:       return 8'h01;
			4:       return ($urandom_range(0, 1) != 0) ? 8'hAA : 8'h55;
			default: return COLOR_W'($urandom());
		endcase
	endfunction

	// mostly whole frames; a few stray single-pixel frames and open runs as noise
	task automatic queue_random_pixels(int count);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0:       len = 1;
				1:       len = $urandom_range(12, 20);
				default: len = $urandom_range(2, 8);
			endcase
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++)
				queue_pixel(pick_color(), pick_color(), pick_color(),
					(i == len - 1) && ($urandom_range(0, 7) != 0));
			left -= len;
		end
	endtask

	// sender holds back until every pulse has come out, then lets the pipeline settle
	task automatic wait_drained();
		while (pixels_taken != pixels_queued || expected_pulses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		pixel_ch.valid     = 1'b0;
		pixel_ch.green     = '0;
		pixel_ch.red       = '0;
		pixel_ch.blue      = '0;
		pixel_ch.frame_end = 1'b0;
		pulse_ch.ready     = 1'b0;
		timing_regs.zero_high = ZERO_HIGH_RST;
		timing_regs.zero_low  = ZERO_LOW_RST;
		timing_regs.one_high  = ONE_HIGH_RST;
		timing_regs.one_low   = ONE_LOW_RST;
		timing_regs.latch     = LATCH_RST;
		pixels_queued   = 0;
		pixels_taken    = 0;
		frames_taken    = 0;
		pulses_checked  = 0;
		fail_count      = 0;
		reg_writes      = 0;
		timing_sets     = 0;
		long_stalls_req = 0;
		cycle_count     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset timing: color extremes, bit order, frame end on its own and in a frame
		queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
		queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
		queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_pixel(8'h80, 8'h00, 8'h00, 1'b0);
		queue_pixel(8'h00, 8'h01, 8'h00, 1'b0);
		queue_pixel(8'h00, 8'h00, 8'h80, 1'b0);
		queue_pixel(8'h01, 8'h80, 8'h01, 1'b1);
		queue_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		queue_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
		queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
		queue_pixel(8'h0F, 8'hF0, 8'h3C, 1'b1);
		wait_drained();

		// largest timings, written with junk above the register width
		set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		cfg_write(REG_SPARE_LO, 32'h0000_0001);
		cfg_write(REG_SPARE_HI, 32'hDEAD_BEEF);
		queue_random_pixels(PHASE_PIXELS);
		long_stalls_req++;
		wait_drained();

		// smallest nonzero timings
		set_timing(1, 1, 1, 1, 1);
		queue_random_pixels(PHASE_PIXELS);
		wait_drained();

		// zero in every timing register passes straight through
		set_timing(0, 0, 0, 0, 0);
		cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
		queue_random_pixels(PHASE_PIXELS);
		wait_drained();

		set_timing($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		queue_random_pixels(PHASE_PIXELS);
		wait_drained();

		// back to the default timings, with one more long receiver hold-off
		set_timing(PDATA_W'(ZERO_HIGH_RST), PDATA_W'(ZERO_LOW_RST), PDATA_W'(ONE_HIGH_RST),
			PDATA_W'(ONE_LOW_RST), PDATA_W'(LATCH_RST));
		queue_random_pixels(PHASE_PIXELS);
		long_stalls_req++;
		wait_drained();

		$display("%0d pixels in %0d frames sent, %0d pulses checked",
			pixels_taken, frames_taken, pulses_checked);
		$display("%0d register writes over %0d timing sets, %0d long output stalls",
			reg_writes, timing_sets, long_stalls_req);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d pulse errors", fail_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/aled_pkg.sv
sv/aled_if.sv
sv/aled_cfg.sv
sv/aled_front.sv
sv/aled_fifo.sv
sv/aled_back.sv
sv/addressable_led_bit_encoder.sv
verif/addressable_led_bit_encoder_test.sv
